@@ sv/dtq_pkg.sv @@
`timescale 1ns / 1ps
package dtq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ID_W = 16;
    localparam int TIME_W = 63;
    localparam int CFG_W = 20;
    localparam logic [CFG_W-1:0] MIN_REARM_RESET = CFG_W'(100);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
        logic more_due;
    } t_stat;

endpackage

@@ sv/dtq_ctrl.sv @@
`timescale 1ns / 1ps
module dtq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  dtq_pkg::t_stat i_stat,
    output dtq_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);
    import dtq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.more_due ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_SCAN: o_cmd.step = 1'b1;
            S_DONE: o_cmd.commit = i_stat.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

@@ sv/dtq_dp.sv @@
`timescale 1ns / 1ps
module dtq_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtq_pkg::t_cmd                i_cmd,
    output dtq_pkg::t_stat               o_stat,
    input  logic                         i_cfg_wr_en,
    input  logic [dtq_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic [1:0]                   i_action,
    input  logic [dtq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [dtq_pkg::TIME_W-1:0]   i_expiry_time,
    input  logic [dtq_pkg::TIME_W-1:0]   i_repeat_interval,
    input  logic [dtq_pkg::TIME_W-1:0]   i_now_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic                         o_expired_valid,
    output logic [dtq_pkg::ID_W-1:0]     o_expired_id,
    output logic                         o_last,
    output logic                         o_rearm_valid,
    output logic [dtq_pkg::TIME_W-1:0]   o_rearm_delay
);
    import dtq_pkg::*;

    logic [CFG_W-1:0]  r_min_rearm;
    logic [CAPACITY-1:0] r_valid;
    logic [ID_W-1:0]   r_id [CAPACITY];
    t_time             r_dl [CAPACITY];
    t_time             r_per [CAPACITY];

    t_action           r_act;
    logic [ID_W-1:0]   r_req_id;
    t_time             r_req_exp;
    t_time             r_req_per;
    t_time             r_req_now;

    t_idx              r_idx;
    logic              r_match;
    t_idx              r_match_slot;
    logic              r_free;
    t_idx              r_free_slot;
    logic              r_earliest;
    logic              r_due;
    logic              r_due2;
    t_idx              r_due_slot;
    t_time             r_due_dl;
    logic [ID_W-1:0]   r_due_id;
    t_time             r_due_per;
    logic              r_any;
    t_time             r_min_dl;

    logic              r_out_valid;
    logic [1:0]        r_status;
    logic              r_exp_valid;
    logic [ID_W-1:0]   r_exp_id;
    logic              r_last;
    logic              r_rearm_valid;
    t_time             r_rearm_delay;

    logic              s_v;
    logic [ID_W-1:0]   s_id;
    t_time             s_dl;
    logic [TIME_W:0]   sum;
    t_time             resched;
    t_time             next_min;

    function automatic t_time clamp(input t_time dl, input t_time now,
                                    input logic [CFG_W-1:0] lo);
        t_time d;
        d = (dl > now) ? dl - now : '0;
        if (d < TIME_W'(lo)) begin
            d = TIME_W'(lo);
        end
        return d;
    endfunction

    assign s_v  = r_valid[r_idx];
    assign s_id = r_id[r_idx];
    assign s_dl = r_dl[r_idx];
    assign sum  = {1'b0, r_req_now} + {1'b0, r_due_per};
    assign resched = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    assign next_min = (r_due_per != '0 && (!r_any || resched < r_min_dl)) ? resched : r_min_dl;

    assign o_stat.scan_last = (r_idx == LAST_IDX);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.more_due  = (r_act == ACT_TICK) && r_due && r_due2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rearm <= MIN_REARM_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_rearm <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act     <= t_action'(i_action);
            r_req_id  <= i_timer_id;
            r_req_exp <= i_expiry_time;
            r_req_per <= i_repeat_interval;
            r_req_now <= i_now_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept || i_cmd.commit) begin
            r_idx      <= '0;
            r_match    <= 1'b0;
            r_free     <= 1'b0;
            r_earliest <= 1'b1;
            r_due      <= 1'b0;
            r_due2     <= 1'b0;
            r_any      <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (s_v && s_id == r_req_id && !r_match) begin
                r_match      <= 1'b1;
                r_match_slot <= r_idx;
            end
            if (!s_v && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= r_idx;
            end
            if (s_v && s_dl <= r_req_exp) begin
                r_earliest <= 1'b0;
            end
            if (s_v && s_dl <= r_req_now && r_due) begin
                r_due2 <= 1'b1;
            end
            if (s_v && s_dl <= r_req_now && (!r_due || s_dl < r_due_dl
                    || (s_dl == r_due_dl && s_id < r_due_id))) begin
                r_due      <= 1'b1;
                r_due_slot <= r_idx;
                r_due_dl   <= s_dl;
                r_due_id   <= s_id;
                r_due_per  <= r_per[r_idx];
            end
            if (s_v && s_dl > r_req_now && (!r_any || s_dl < r_min_dl)) begin
                r_any    <= 1'b1;
                r_min_dl <= s_dl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            case (r_act)
                ACT_ADD: begin
                    if (!r_match && r_free) begin
                        r_valid[r_free_slot] <= 1'b1;
                    end
                end
                ACT_CANCEL: begin
                    if (r_match) begin
                        r_valid[r_match_slot] <= 1'b0;
                    end
                end
                ACT_TICK: begin
                    if (r_due && r_due_per == '0) begin
                        r_valid[r_due_slot] <= 1'b0;
                    end
                end
                default: r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_act == ACT_ADD && !r_match && r_free) begin
                r_id[r_free_slot]  <= r_req_id;
                r_dl[r_free_slot]  <= r_req_exp;
                r_per[r_free_slot] <= r_req_per;
            end else if (r_act == ACT_TICK && r_due && r_due_per != '0) begin
                r_dl[r_due_slot] <= resched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= ST_OK;
            r_exp_valid   <= 1'b0;
            r_exp_id      <= '0;
            r_last        <= 1'b1;
            r_rearm_valid <= 1'b0;
            r_rearm_delay <= '0;
            case (r_act)
                ACT_ADD: begin
                    if (r_match) begin
                        r_status <= ST_DUPLICATE;
                    end else if (!r_free) begin
                        r_status <= ST_FULL;
                    end else if (r_earliest) begin
                        r_rearm_valid <= 1'b1;
                        r_rearm_delay <= clamp(r_req_exp, r_req_now, r_min_rearm);
                    end
                end
                ACT_CANCEL: begin
                    if (!r_match) begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                ACT_TICK: begin
                    if (r_due) begin
                        r_exp_valid <= 1'b1;
                        r_exp_id    <= r_due_id;
                        r_last      <= !r_due2;
                        if (!r_due2 && (r_any || r_due_per != '0)) begin
                            r_rearm_valid <= 1'b1;
                            r_rearm_delay <= clamp(next_min, r_req_now, r_min_rearm);
                        end
                    end else if (r_any) begin
                        r_rearm_valid <= 1'b1;
                        r_rearm_delay <= clamp(r_min_dl, r_req_now, r_min_rearm);
                    end
                end
                default: r_status <= ST_OK;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_expired_valid = r_exp_valid;
    assign o_expired_id    = r_exp_id;
    assign o_last          = r_last;
    assign o_rearm_valid   = r_rearm_valid;
    assign o_rearm_delay   = r_rearm_delay;

endmodule

@@ sv/deadline_timer_queue.sv @@
`timescale 1ns / 1ps
// Add, cancel and no-op requests: one result, registered after a table scan and a commit.
// Tick requests: a table scan plus a commit per result, giving max(k, 1) results
// for k expired timers, the final one marked by o_last.
// One request at a time; a commit waits while a stall holds the result register,
// and the next request can be taken in the cycle after the final result is registered.
// Synchronous active-low reset empties the table and sets the minimum delay to 100.
module deadline_timer_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [dtq_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [dtq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [dtq_pkg::TIME_W-1:0]   i_expiry_time,
    input  logic [dtq_pkg::TIME_W-1:0]   i_repeat_interval,
    input  logic [dtq_pkg::TIME_W-1:0]   i_now_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic                         o_expired_valid,
    output logic [dtq_pkg::ID_W-1:0]     o_expired_id,
    output logic                         o_last,
    output logic                         o_rearm_valid,
    output logic [dtq_pkg::TIME_W-1:0]   o_rearm_delay
);
    import dtq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dtq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_action          (i_action),
        .i_timer_id        (i_timer_id),
        .i_expiry_time     (i_expiry_time),
        .i_repeat_interval (i_repeat_interval),
        .i_now_time        (i_now_time),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_expired_valid   (o_expired_valid),
        .o_expired_id      (o_expired_id),
        .o_last            (o_last),
        .o_rearm_valid     (o_rearm_valid),
        .o_rearm_delay     (o_rearm_delay)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import dtq_pkg::*;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  SETTLE = 400;
    localparam t_time TMAX = {TIME_W{1'b1}};

    typedef struct {
        logic [1:0]      status;
        logic            ev;
        logic [ID_W-1:0] eid;
        logic            last;
        logic            rv;
        t_time           rd;
    } t_timer_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        action;
    logic [ID_W-1:0]   timer_id;
    t_time             expiry_time;
    t_time             repeat_interval;
    t_time             now_time;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic              expired_valid;
    logic [ID_W-1:0]   expired_id;
    logic              last;
    logic              rearm_valid;
    t_time             rearm_delay;

    deadline_timer_queue DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(action), .i_timer_id(timer_id), .i_expiry_time(expiry_time),
        .i_repeat_interval(repeat_interval), .i_now_time(now_time),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_expired_valid(expired_valid), .o_expired_id(expired_id),
        .o_last(last), .o_rearm_valid(rearm_valid), .o_rearm_delay(rearm_delay)
    );

    // timer table mirror
    logic             tbl_valid [CAPACITY];
    logic [ID_W-1:0]  tbl_id [CAPACITY];
    t_time            tbl_deadline [CAPACITY];
    t_time            tbl_period [CAPACITY];
    logic [CFG_W-1:0] min_delay;

    t_timer_result expected_q[$];
    int  errors = 0;
    int  requests_sent = 0;
    int  results_seen = 0;
    int  expirations_seen = 0;
    int  cycles = 0;
    int  hold_cycles = 0;
    int  stall_left = 0;
    bit  send_idle = 1;
    bit  recv_idle = 1;
    t_time clock_us = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_time rand63();
        return t_time'({$urandom, $urandom});
    endfunction

    function automatic t_time clamp_delay(t_time deadline, t_time now);
        t_time d;
        d = (deadline > now) ? deadline - now : '0;
        if (d < t_time'(min_delay))
            d = t_time'(min_delay);
        return d;
    endfunction

    function automatic void push_result(logic [1:0] st, logic ev, logic [ID_W-1:0] eid,
                                        logic lst, logic rv, t_time rd);
        t_timer_result r;
        r.status = st; r.ev = ev; r.eid = eid; r.last = lst; r.rv = rv; r.rd = rd;
        expected_q.push_back(r);
    endfunction

    function automatic int find_timer(logic [ID_W-1:0] id);
        for (int i = 0; i < CAPACITY; i++)
            if (tbl_valid[i] && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void predict_request(t_action act, logic [ID_W-1:0] id,
                                            t_time expiry, t_time period, t_time now);
        int     free_slot;
        int     best;
        int     n;
        int     s;
        bit     earliest;
        bit     any;
        t_time  next_dl;
        logic [63:0] nd;
        free_slot = -1;
        earliest = 1;
        n = 0;
        any = 0;
        next_dl = '0;
        case (act)
            ACT_ADD: begin
                if (find_timer(id) >= 0) begin
                    push_result(ST_DUPLICATE, 0, '0, 1, 0, '0);
                    return;
                end
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_deadline[i] <= expiry) earliest = 0;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (free_slot < 0) begin
                    push_result(ST_FULL, 0, '0, 1, 0, '0);
                    return;
                end
                tbl_valid[free_slot] = 1;
                tbl_id[free_slot] = id;
                tbl_deadline[free_slot] = expiry;
                tbl_period[free_slot] = period;
                if (earliest) push_result(ST_OK, 0, '0, 1, 1, clamp_delay(expiry, now));
                else          push_result(ST_OK, 0, '0, 1, 0, '0);
            end
            ACT_CANCEL: begin
                s = find_timer(id);
                if (s < 0) begin
                    push_result(ST_NOT_FOUND, 0, '0, 1, 0, '0);
                end else begin
                    tbl_valid[s] = 0;
                    push_result(ST_OK, 0, '0, 1, 0, '0);
                end
            end
            ACT_TICK: begin
                forever begin
                    best = -1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!tbl_valid[i] || tbl_deadline[i] > now) continue;
                        if (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
                            (tbl_deadline[i] == tbl_deadline[best] && tbl_id[i] < tbl_id[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    push_result(ST_OK, 1, tbl_id[best], 0, 0, '0);
                    n++;
                    if (tbl_period[best] != '0) begin
                        nd = {1'b0, now} + {1'b0, tbl_period[best]};
                        tbl_deadline[best] = (nd > {1'b0, TMAX}) ? TMAX : nd[TIME_W-1:0];
                    end else begin
                        tbl_valid[best] = 0;
                    end
                end
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tbl_valid[i] && (!any || tbl_deadline[i] < next_dl)) begin
                        next_dl = tbl_deadline[i];
                        any = 1;
                    end
                end
                if (n == 0) push_result(ST_OK, 0, '0, 0, 0, '0);
                expected_q[$].last = 1;
                expected_q[$].rv = any;
                expected_q[$].rd = any ? clamp_delay(next_dl, now) : '0;
            end
            default: push_result(ST_OK, 0, '0, 1, 0, '0);
        endcase
    endfunction

    task automatic send_request(t_action act, logic [ID_W-1:0] id, t_time expiry,
                                t_time period, t_time now);
        int gap;
        gap = send_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1;
        action <= act;
        timer_id <= id;
        expiry_time <= expiry;
        repeat_interval <= period;
        now_time <= now;
        do @(posedge i_clk); while (in_stall);
        predict_request(act, id, expiry, period, now);
        requests_sent++;
    endtask

    task automatic drain_all();
        in_valid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_min_delay(logic [CFG_W-1:0] value);
        drain_all();
        cfg_wr_en <= 1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        min_delay = value;
        cfg_wr_en <= 0;
    endtask

    // result side: random stall per result, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (out_valid && !out_stall)
            stall_left = recv_idle ? $urandom_range(0, 17) : 0;
        if (hold_cycles > 0) begin
            out_stall <= 1;
            hold_cycles--;
        end else begin
            out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        t_timer_result e;
        if (i_rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d id=%0d", $time, status, expired_id);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (expired_valid) expirations_seen++;
                if (status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, status);
                    errors++;
                end
                if (expired_valid !== e.ev) begin
                    $display("%0t: expired_valid exp %0d got %0d", $time, e.ev, expired_valid);
                    errors++;
                end
                if (expired_id !== e.eid) begin
                    $display("%0t: expired_id exp %0d got %0d", $time, e.eid, expired_id);
                    errors++;
                end
                if (last !== e.last) begin
                    $display("%0t: last exp %0d got %0d", $time, e.last, last);
                    errors++;
                end
                if (rearm_valid !== e.rv) begin
                    $display("%0t: rearm_valid exp %0d got %0d", $time, e.rv, rearm_valid);
                    errors++;
                end
                if (rearm_delay !== e.rd) begin
                    $display("%0t: rearm_delay exp %0d got %0d", $time, e.rd, rearm_delay);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_request(ACT_TICK, 0, '0, '0, '0);
        send_request(ACT_ADD, 16'h0005, 500, 0, 100);
        send_request(ACT_ADD, 16'h0005, 50, 0, 100);
        send_request(ACT_CANCEL, 16'hFFFF, '0, '0, '0);
        send_request(ACT_ADD, 16'h0003, 900, 0, 100);
        send_request(ACT_ADD, 16'h0000, 20, 0, 100);
        send_request(ACT_ADD, 16'hFFFF, TMAX, TMAX, TMAX);
        send_request(ACT_NOP, 16'hFFFF, TMAX, TMAX, TMAX);
        for (int i = 0; i < 13; i++)
            send_request(ACT_ADD, 16'(100 + i), 900, (i % 2) ? t_time'(50) : t_time'(0), 100);
        send_request(ACT_ADD, 16'h7777, 1, 0, 0);
        send_request(ACT_ADD, 16'h0003, 1, 0, 0);
        send_request(ACT_CANCEL, 16'hFFFF, '0, '0, '0);
        send_request(ACT_ADD, 16'h0001, TMAX - 1, TMAX, 0);
        send_request(ACT_TICK, 0, '0, '0, TMAX - 1);
        send_request(ACT_TICK, 0, '0, '0, 1000);
        clock_us = 1000;
    endtask

    task automatic random_request();
        int       pick;
        logic [ID_W-1:0] id;
        t_time    expiry;
        t_time    period;
        pick = $urandom_range(0, 99);
        id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
        case ($urandom_range(0, 9))
            0:       expiry = rand63();
            1:       expiry = clock_us - t_time'($urandom_range(0, 300));
            default: expiry = clock_us + t_time'($urandom_range(0, 6000));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: period = '0;
            4:          period = rand63();
            default:    period = t_time'($urandom_range(1, 4000));
        endcase
        if (pick < 45) begin
            send_request(ACT_ADD, id, expiry, period,
                         ($urandom_range(0, 19) == 0) ? rand63() : clock_us);
        end else if (pick < 65) begin
            send_request(ACT_CANCEL, id, rand63(), rand63(), rand63());
        end else if (pick < 95) begin
            clock_us += t_time'($urandom_range(0, 3000));
            send_request(ACT_TICK, 16'($urandom), rand63(), rand63(), clock_us);
        end else begin
            send_request(ACT_NOP, 16'($urandom), rand63(), rand63(), rand63());
        end
    endtask

    task automatic test_config_sweep();
        logic [CFG_W-1:0] settings [5];
        settings = '{20'd0, 20'hFFFFF, 20'd1, 20'($urandom), 20'd100};
        foreach (settings[k]) begin
            write_min_delay(settings[k]);
            for (int i = 0; i < 40; i++) random_request();
        end
    endtask

    task automatic test_backpressure();
        drain_all();
        send_idle = 0;
        hold_cycles = 1500;
        for (int i = 0; i < 30; i++) random_request();
        send_idle = 1;
        drain_all();
    endtask

    task automatic test_random();
        for (int i = 0; i < 220; i++) begin
            if (i % 55 == 0) begin
                send_idle = $urandom_range(0, 1);
                recv_idle = $urandom_range(0, 1);
            end
            random_request();
        end
        send_idle = 1;
        recv_idle = 1;
    endtask

    initial begin
        i_rst_n <= 0;
        cfg_wr_en <= 0;
        cfg_wr_data <= '0;
        in_valid <= 0;
        action <= ACT_NOP;
        timer_id <= '0;
        expiry_time <= '0;
        repeat_interval <= '0;
        now_time <= '0;
        out_stall <= 0;
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        min_delay = MIN_REARM_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        drain_all();
        $display("Covered %0d requests, %0d results, %0d expirations, 5 delay settings,",
                 requests_sent, results_seen, expirations_seen);
        $display("a long result hold-off and random gaps on both sides.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
